### sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority queue
// Request and response payloads, action codes and the structs that run
// between the compare cells of the chain.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 4;
  localparam int unsigned LengthW = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [ValueW-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     found;
    logic [PosW-1:0]          position;
    logic                     overflow;
    logic [LengthW-1:0]       length;
    logic                     head_valid;
    logic signed [ValueW-1:0] head_value;
  } rsp_t;

  // Command broadcast to every cell in the cycle a request is taken.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [ValueW-1:0] value;
  } cmd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic                     valid;
    logic                     lt;
    logic                     eq;
    logic signed [ValueW-1:0] value;
  } link_t;

endpackage

### sv/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: descending sorted queue of signed values
// A chain of DEPTH compare cells; insert, remove and find finish in the cycle
// the request is taken and the response is registered.
// ----------------------------------------------------------------------------
// The response is registered and valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the response side stays ready. A waiting
// response holds off the next request until the cycle in which it is taken.
// Reset: queue empty, no response pending; stored values need no clearing.
module sorted_priority_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  spq_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output spq_pkg::rsp_t out_rsp_o
);
  import spq_pkg::*;

  localparam int unsigned CountW = $clog2(DEPTH + 1);

  logic              accept;
  logic              full, found;
  logic              is_ins, is_rem, is_find;
  cmd_t              cmd;
  link_t             links [DEPTH];
  logic [DEPTH-1:0]  first;
  logic [DEPTH-1:0]  valid_d;
  logic [31:0]       value_d [DEPTH];
  logic [PosW-1:0]   pos;
  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q;
  rsp_t              rsp_q, rsp_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_ins  = in_req_i.action == ACT_INSERT;
  assign is_rem  = in_req_i.action == ACT_REMOVE;
  assign is_find = in_req_i.action == ACT_FIND;
  assign full    = links[DEPTH-1].valid;
  assign found   = (is_rem || is_find) && (|first);

  assign cmd = '{ins: accept && is_ins && !full,
                 rem: accept && is_rem && found,
                 value: in_req_i.value};

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    link_t prev_l, next_l;
    if (g == 0) begin : g_head
      assign prev_l = '{valid: 1'b1, lt: 1'b0, eq: 1'b0, value: '0};
    end else begin : g_mid
      assign prev_l = links[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign next_l = '{valid: 1'b0, lt: 1'b0, eq: 1'b0, value: '0};
    end else begin : g_body
      assign next_l = links[g+1];
    end
    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .key_i     (in_req_i.value),
      .cmd_i     (cmd),
      .prev_i    (prev_l),
      .next_i    (next_l),
      .link_o    (links[g]),
      .first_o   (first[g]),
      .valid_d_o (valid_d[g]),
      .value_d_o (value_d[g])
    );
  end

  // At most one cell flags a first match, so OR-ing the indices encodes it.
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        pos = pos | PosW'(i);
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CountW'(1);
    end else if (cmd.rem) begin
      count_d = count_q - CountW'(1);
    end

    rsp_d.found      = found;
    rsp_d.position   = found ? pos : '0;
    rsp_d.overflow   = is_ins && full;
    rsp_d.length     = LengthW'(count_d);
    rsp_d.head_valid = valid_d[0];
    rsp_d.head_value = valid_d[0] ? value_d[0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // The fill count and the occupancy of the chain must agree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) == links[0].valid)
    else $error("count and head occupancy disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (count_q == CountW'(DEPTH)))
    else $error("tail cell occupied but count is not DEPTH");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(first))
    else $error("more than one cell flags a first match");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && rsp_q.overflow) |-> !rsp_q.found)
    else $error("overflow response also reports a match");

endmodule

### sv/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one value, compares it with the broadcast key and moves data to or
// from its neighbors for insert and remove.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [spq_pkg::ValueW-1:0] key_i,
  input  spq_pkg::cmd_t                     cmd_i,
  input  spq_pkg::link_t                    prev_i,
  input  spq_pkg::link_t                    next_i,
  output spq_pkg::link_t                    link_o,
  output logic                              first_o,
  output logic                              valid_d_o,
  output logic [31:0]                       value_d_o
);
  import spq_pkg::*;

  logic                     valid_q, valid_d;
  logic signed [ValueW-1:0] value_q, value_d;
  logic                     gt, lt, eq;
  logic                     ins_here, shift_in, pull;

  always_comb begin
    // The compare runs on the raw key so the match flags never depend on the
    // command that they help to build.
    gt = valid_q && (value_q > key_i);
    lt = valid_q && (value_q < key_i);
    eq = valid_q && (value_q == key_i);

    // The key goes before the first strictly smaller value, or at the tail.
    ins_here = cmd_i.ins && !prev_i.lt && (lt || (!valid_q && prev_i.valid));
    shift_in = cmd_i.ins && prev_i.lt;
    // Equal values are contiguous, so every cell from the first match on
    // that is not greater than the key pulls from its successor.
    pull     = cmd_i.rem && valid_q && !gt;

    valid_d = valid_q;
    value_d = value_q;
    if (ins_here) begin
      valid_d = 1'b1;
      value_d = cmd_i.value;
    end else if (shift_in) begin
      valid_d = 1'b1;
      value_d = prev_i.value;
    end else if (pull) begin
      valid_d = next_i.valid;
      value_d = next_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o    = '{valid: valid_q, lt: lt, eq: eq, value: value_q};
  assign first_o   = eq && !prev_i.eq;
  assign valid_d_o = valid_d;
  assign value_d_o = value_d;

endmodule

### sim/tb_sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_unit: testbench for the sorted priority queue
// Keeps a shadow copy of the queue, predicts one response per request and
// compares each response field by field. Directed checks, fill and overflow,
// random traffic, output backpressure and a full drain are run in turn.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_unit;
  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic signed [ValueW-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [ValueW-1:0] VAL_MIN = 32'sh8000_0000;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_ready_o;
  req_t in_req;
  logic out_valid_o;
  logic out_ready;
  rsp_t out_rsp_o;

  // Shadow of the stored values, head first, and the responses still owed.
  logic signed [ValueW-1:0] shadow_queue[$];
  rsp_t pending_rsp[$];

  int send_gap_max;
  int recv_gap_max;
  int recv_hold;
  bit mismatch_seen;

  sorted_priority_queue_unit #(
    .DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Applies one request to the shadow queue and returns the response it owes.
  function automatic rsp_t predict_queue_op(logic [1:0] act, logic signed [ValueW-1:0] val);
    rsp_t rsp;
    int at;
    rsp = '0;
    at = -1;
    if (act == ACT_INSERT) begin
      if (shadow_queue.size() >= QUEUE_DEPTH) begin
        rsp.overflow = 1'b1;
      end else begin
        // Place before the first strictly smaller value, so ties keep order.
        at = shadow_queue.size();
        for (int i = shadow_queue.size() - 1; i >= 0; i--) begin
          if (shadow_queue[i] < val) at = i;
        end
        shadow_queue.insert(at, val);
      end
    end else if (act == ACT_REMOVE || act == ACT_FIND) begin
      for (int i = shadow_queue.size() - 1; i >= 0; i--) begin
        if (shadow_queue[i] == val) at = i;
      end
      if (at >= 0) begin
        rsp.found = 1'b1;
        rsp.position = at[PosW-1:0];
        if (act == ACT_REMOVE) shadow_queue.delete(at);
      end
    end
    rsp.length = LengthW'(shadow_queue.size());
    rsp.head_valid = shadow_queue.size() != 0;
    rsp.head_value = (shadow_queue.size() != 0) ? shadow_queue[0] : '0;
    return rsp;
  endfunction

  function automatic void compare_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_seen = 1'b1;
    end
  endfunction

  task automatic check_response(input rsp_t got);
    rsp_t want;
    if (pending_rsp.size() == 0) begin
      $error("response with no request outstanding: %h", got);
      mismatch_seen = 1'b1;
    end else begin
      want = pending_rsp.pop_front();
      compare_field("found", want.found, got.found);
      compare_field("position", want.position, got.position);
      compare_field("overflow", want.overflow, got.overflow);
      compare_field("length", want.length, got.length);
      compare_field("head_valid", want.head_valid, got.head_valid);
      compare_field("head_value", $signed(want.head_value), $signed(got.head_value));
    end
  endtask

  // Starts after the previous request was taken; valid stays high on a zero gap.
  task automatic send_request(logic [1:0] act, logic signed [ValueW-1:0] val);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_req <= '{action: act, value: val};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_rsp.push_back(predict_queue_op(act, val));
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [ValueW-1:0] pick_value(bit prefer_held);
    logic signed [ValueW-1:0] v;
    int sel;
    sel = $urandom_range(0, 9);
    if (prefer_held && shadow_queue.size() != 0 && sel < 7) begin
      v = shadow_queue[$urandom_range(0, shadow_queue.size() - 1)];
    end else if (sel < 4) begin
      v = $urandom_range(0, 16) - 8;
    end else if (sel < 7) begin
      v = $urandom;
    end else if (sel == 7) begin
      case ($urandom_range(0, 3))
        0: v = VAL_MAX;
        1: v = VAL_MIN;
        2: v = '0;
        default: v = '1;
      endcase
    end else if (shadow_queue.size() != 0) begin
      v = shadow_queue[$urandom_range(0, shadow_queue.size() - 1)] + ((sel == 8) ? 1 : -1);
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Leans toward inserts when nearly empty and removes when nearly full.
  function automatic logic [1:0] pick_action();
    int sel;
    int ins_limit;
    sel = $urandom_range(0, 19);
    if (shadow_queue.size() < 4) ins_limit = 13;
    else if (shadow_queue.size() > 12) ins_limit = 6;
    else ins_limit = 9;
    if (sel == 0) return ACT_UNUSED;
    if (sel < ins_limit) return ACT_INSERT;
    if (sel < 16) return ACT_REMOVE;
    return ACT_FIND;
  endfunction

  task automatic send_random(int n);
    logic [1:0] act;
    for (int i = 0; i < n; i++) begin
      act = pick_action();
      send_request(act, pick_value(act != ACT_INSERT));
    end
  endtask

  task automatic test_directed_ops();
    send_request(ACT_FIND, 32'sd5);
    send_request(ACT_REMOVE, 32'sd5);
    send_request(ACT_UNUSED, '0);
    send_request(ACT_INSERT, 32'sd0);
    send_request(ACT_INSERT, VAL_MAX);
    send_request(ACT_INSERT, VAL_MIN);
    send_request(ACT_INSERT, -32'sd1);
    send_request(ACT_INSERT, 32'sd0);
    send_request(ACT_INSERT, 32'sd7);
    send_request(ACT_FIND, 32'sd0);
    send_request(ACT_FIND, VAL_MIN);
    send_request(ACT_FIND, 32'sd3);
    send_request(ACT_REMOVE, 32'sd0);
    send_request(ACT_FIND, 32'sd0);
    send_request(ACT_REMOVE, -32'sd1);
    send_request(ACT_REMOVE, 32'sd99);
    send_request(ACT_UNUSED, VAL_MAX);
    send_request(ACT_REMOVE, VAL_MAX);
    send_request(ACT_FIND, 32'sd7);
    send_request(ACT_INSERT, VAL_MAX);
    send_request(ACT_INSERT, VAL_MIN);
  endtask

  // Fills the queue, pushes inserts past full, then empties it again.
  task automatic test_fill_and_overflow();
    while (shadow_queue.size() < QUEUE_DEPTH) send_request(ACT_INSERT, pick_value(1'b0));
    send_request(ACT_FIND, shadow_queue[QUEUE_DEPTH-1]);
    send_request(ACT_FIND, VAL_MIN);
    for (int i = 0; i < 3; i++) send_request(ACT_INSERT, pick_value(1'b0));
    send_request(ACT_INSERT, VAL_MAX);
    while (shadow_queue.size() != 0) begin
      send_request(ACT_REMOVE, shadow_queue[$urandom_range(0, shadow_queue.size() - 1)]);
    end
    send_request(ACT_REMOVE, VAL_MIN);
    send_request(ACT_FIND, '0);
  endtask

  task automatic test_random_mix(int n, int send_max, int recv_max);
    send_gap_max = send_max;
    recv_gap_max = recv_max;
    send_random(n);
  endtask

  // The receiver stops for a long stretch while requests keep coming.
  task automatic test_output_stall();
    send_gap_max = 0;
    recv_gap_max = 0;
    recv_hold = 60;
    send_random(40);
  endtask

  task automatic test_drain_pause();
    send_gap_max = 2;
    recv_gap_max = 5;
    send_random(20);
    wait_for_drain();
    send_random(20);
  endtask

  initial begin
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      int gap;
      @(negedge clk_i);
      gap = (recv_hold > 0) ? recv_hold : $urandom_range(0, recv_gap_max);
      recv_hold = 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      check_response(out_rsp_o);
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    send_gap_max = 5;
    recv_gap_max = 5;
    recv_hold = 0;
    mismatch_seen = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_ops();
    test_fill_and_overflow();
    test_random_mix(270, 0, 0);
    test_output_stall();
    test_random_mix(270, 5, 5);
    test_drain_pause();
    test_random_mix(270, 0, 5);
    test_random_mix(270, 5, 0);

    wait_for_drain();
    repeat (4) @(posedge clk_i);
    if (!mismatch_seen) begin
      $display("tb_sorted_priority_queue_unit passed");
    end else begin
      $display("tb_sorted_priority_queue_unit failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_sorted_priority_queue_unit failed");
    $finish;
  end

endmodule
